### rtl/core/blss_pkg.sv
// ----------------------------------------------------------------------------
// blss_pkg
// Request codes, capacity and item field widths shared by the linked sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

package blss_pkg;

  // Request kinds carried in the input tuser field.
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_DELETE_AT  = 3'd4
  } req_e;

  // Number of slots in the pool; the count and position fields are sized for it.
  localparam int unsigned Capacity = 64;

  localparam int unsigned ReqW    = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned PosW    = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned InDataW = 40;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned OutUserW = 2;

endpackage

`default_nettype wire

### rtl/core/bounded_linked_sequence_store.sv
// ----------------------------------------------------------------------------
// bounded_linked_sequence_store
// Bounded doubly linked deque of signed 32-bit values in a fixed slot pool.
// ----------------------------------------------------------------------------
// Each item is one request and yields exactly one result item. The entries sit
// in three single-port-read memories (values, forward links, backward links)
// with a registered read, so every request is handled by a small sequencer.
// Rejected requests go from decode straight to the result state, pushes and
// end pops pass through their update state, and a delete at a middle position
// walks forward links from the head, one link per cycle, then unlinks the entry.
// Slots never handed out are tracked by a fill counter, so no clearing pass is
// needed after reset. The output register lets a finished result wait while
// the next item is accepted.
`default_nettype none

module bounded_linked_sequence_store (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Input items.
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // [31:0] value, [37:32] position, [39:38] zero
  input  wire logic [blss_pkg::InDataW-1:0]   s_axis_tdata,
  // [2:0] req_type
  input  wire logic [blss_pkg::ReqW-1:0]      s_axis_tuser,
  // Result items.
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // [6:0] count, [38:7] removed_value, [39] zero
  output logic [blss_pkg::OutDataW-1:0]       m_axis_tdata,
  // [0] status, [1] removed_valid
  output logic [blss_pkg::OutUserW-1:0]       m_axis_tuser
);
  import blss_pkg::*;

  localparam int unsigned AW   = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW   = $clog2(Capacity + 1);
  localparam int unsigned CMPW = (CW > PosW) ? CW : PosW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_PUSH, ST_POPF, ST_POPB, ST_WALK, ST_UNLINK, ST_FREE,
    ST_RESULT
  } state_e;

  // Memories.
  logic signed [ValueW-1:0] val_mem [Capacity];
  logic [AW-1:0]            nxt_mem [Capacity];
  logic [AW-1:0]            prv_mem [Capacity];

  logic [AW-1:0]            rd_addr;
  logic signed [ValueW-1:0] val_rd_q;
  logic [AW-1:0]            nxt_rd_q, prv_rd_q;

  logic                     val_we, nxt_we, prv_we;
  logic [AW-1:0]            val_wa, nxt_wa, prv_wa;
  logic signed [ValueW-1:0] val_wd;
  logic [AW-1:0]            nxt_wd, prv_wd;

  // Control and list state.
  state_e                   state_q, state_d;
  logic [AW-1:0]            head_q, head_d, tail_q, tail_d;
  logic [AW-1:0]            free_q, free_d, cur_q, cur_d;
  logic [CW-1:0]            cnt_q, cnt_d, fresh_q, fresh_d;
  logic [PosW-1:0]          step_q, step_d;
  logic [ReqW-1:0]          req_q;
  logic signed [ValueW-1:0] val_q;
  logic [PosW-1:0]          pos_q;
  logic                     rej_q, rej_d, took_q, took_d;
  logic signed [ValueW-1:0] rem_q, rem_d;
  logic                     out_valid_q;
  logic [CountW-1:0]        out_cnt_q;
  logic signed [ValueW-1:0] out_rem_q;
  logic                     out_status_q, out_took_q;

  logic                     full, empty, pos_bad, pos_last, is_fresh, load_out;
  logic [AW-1:0]            free_inc;
  logic [CW-1:0]            cnt_m1;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_rem_q, out_cnt_q};
  assign m_axis_tuser  = {out_took_q, out_status_q};

  assign full     = (cnt_q == CW'(Capacity));
  assign empty    = (cnt_q == '0);
  assign cnt_m1   = cnt_q - CW'(1);
  assign pos_bad  = (CMPW'(pos_q) >= CMPW'(cnt_q));
  assign pos_last = (CMPW'(pos_q) == CMPW'(cnt_m1));
  assign is_fresh = (fresh_q < CW'(Capacity)) && (CW'(free_q) == fresh_q);
  assign free_inc = (free_q == AW'(Capacity - 1)) ? '0 : free_q + AW'(1);
  assign load_out = (state_q == ST_RESULT) && (!out_valid_q || m_axis_tready);

  // Memory ports: one write per array and a shared registered read.
  always_ff @(posedge clk_i) begin
    if (val_we) val_mem[val_wa] <= val_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    val_rd_q <= val_mem[rd_addr];
    nxt_rd_q <= nxt_mem[rd_addr];
    prv_rd_q <= prv_mem[rd_addr];
  end

  // Sequencer for one request.
  always_comb begin
    state_d = state_q;
    head_d  = head_q;
    tail_d  = tail_q;
    free_d  = free_q;
    cur_d   = cur_q;
    cnt_d   = cnt_q;
    fresh_d = fresh_q;
    step_d  = step_q;
    rej_d   = rej_q;
    took_d  = took_q;
    rem_d   = rem_q;
    rd_addr = head_q;
    val_we  = 1'b0; val_wa = free_q; val_wd = val_q;
    nxt_we  = 1'b0; nxt_wa = free_q; nxt_wd = head_q;
    prv_we  = 1'b0; prv_wa = head_q; prv_wd = free_q;
    unique case (state_q) inside
      ST_IDLE: begin
        if (s_axis_tvalid) state_d = ST_DECODE;
      end
      ST_DECODE: begin
        rej_d  = 1'b0;
        took_d = 1'b0;
        rem_d  = '0;
        state_d = ST_RESULT;
        unique case (req_q) inside
          REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
            rd_addr = free_q;
            if (full) rej_d = 1'b1;
            else state_d = ST_PUSH;
          end
          REQ_POP_FRONT: begin
            rd_addr = head_q;
            if (empty) rej_d = 1'b1;
            else state_d = ST_POPF;
          end
          REQ_POP_BACK: begin
            rd_addr = tail_q;
            if (empty) rej_d = 1'b1;
            else state_d = ST_POPB;
          end
          REQ_DELETE_AT: begin
            if (pos_bad) begin
              rej_d = 1'b1;
            end else if (pos_q == '0) begin
              rd_addr = head_q;
              state_d = ST_POPF;
            end else if (pos_last) begin
              rd_addr = tail_q;
              state_d = ST_POPB;
            end else begin
              rd_addr = head_q;
              step_d  = '0;
              state_d = ST_WALK;
            end
          end
          default: rej_d = 1'b1;
        endcase
      end
      ST_PUSH: begin
        val_we = 1'b1;
        if (is_fresh) begin
          free_d  = free_inc;
          fresh_d = fresh_q + CW'(1);
        end else begin
          free_d = nxt_rd_q;
        end
        cnt_d = cnt_q + CW'(1);
        if (empty) begin
          head_d = free_q;
          tail_d = free_q;
        end else if (req_q == REQ_PUSH_FRONT) begin
          nxt_we = 1'b1; nxt_wa = free_q; nxt_wd = head_q;
          prv_we = 1'b1; prv_wa = head_q; prv_wd = free_q;
          head_d = free_q;
        end else begin
          prv_we = 1'b1; prv_wa = free_q; prv_wd = tail_q;
          nxt_we = 1'b1; nxt_wa = tail_q; nxt_wd = free_q;
          tail_d = free_q;
        end
        state_d = ST_RESULT;
      end
      ST_POPF, ST_POPB: begin
        took_d = 1'b1;
        rem_d  = val_rd_q;
        cnt_d  = cnt_m1;
        nxt_we = 1'b1;
        nxt_wa = (state_q == ST_POPF) ? head_q : tail_q;
        nxt_wd = free_q;
        free_d = nxt_wa;
        if (cnt_q == CW'(1)) begin
          head_d = '0;
          tail_d = '0;
        end else if (state_q == ST_POPF) begin
          head_d = nxt_rd_q;
        end else begin
          tail_d = prv_rd_q;
        end
        state_d = ST_RESULT;
      end
      ST_WALK: begin
        // One forward link per cycle, read address taken from the last read.
        rd_addr = nxt_rd_q;
        cur_d   = nxt_rd_q;
        step_d  = step_q + PosW'(1);
        if (step_d == pos_q) state_d = ST_UNLINK;
      end
      ST_UNLINK: begin
        rem_d  = val_rd_q;
        nxt_we = 1'b1; nxt_wa = prv_rd_q; nxt_wd = nxt_rd_q;
        prv_we = 1'b1; prv_wa = nxt_rd_q; prv_wd = prv_rd_q;
        state_d = ST_FREE;
      end
      ST_FREE: begin
        // A middle entry always leaves at least two behind.
        took_d = 1'b1;
        nxt_we = 1'b1; nxt_wa = cur_q; nxt_wd = free_q;
        free_d = cur_q;
        cnt_d  = cnt_m1;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (load_out) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State, list registers and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      head_q       <= '0;
      tail_q       <= '0;
      free_q       <= '0;
      cnt_q        <= '0;
      fresh_q      <= '0;
      out_valid_q  <= 1'b0;
      out_status_q <= 1'b0;
      out_took_q   <= 1'b0;
      out_rem_q    <= '0;
      out_cnt_q    <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      free_q  <= free_d;
      cnt_q   <= cnt_d;
      fresh_q <= fresh_d;
      if (load_out) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      if (load_out) begin
        out_status_q <= rej_q;
        out_took_q   <= took_q;
        out_rem_q    <= took_q ? rem_q : '0;
        out_cnt_q    <= CountW'(cnt_q);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    step_q <= step_d;
    rej_q  <= rej_d;
    took_q <= took_d;
    rem_q  <= rem_d;
    if (s_axis_tvalid && s_axis_tready) begin
      req_q <= s_axis_tuser;
      val_q <= s_axis_tdata[ValueW-1:0];
      pos_q <= s_axis_tdata[ValueW +: PosW];
    end
  end

endmodule

`default_nettype wire
